// ===== rtl/breakpoint_comparator_table_core_defines.svh =====
// Assertion macros for the breakpoint comparator table.
// Used by the top level; needs clk and rst_n in scope where expanded.
`ifndef BREAKPOINT_COMPARATOR_TABLE_CORE_DEFINES_SVH
`define BREAKPOINT_COMPARATOR_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bct check failed");
`define BCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bct check failed");
`else
`define BCT_ASSERT_NOW(label, ante, cons)
`define BCT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/bct_pkg.sv =====
// Shared constants and the token type that walks the breakpoint cell chain.
// No dependencies.
`default_nettype none
package bct_pkg;

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 8;
  localparam int STS_W  = 2;
  localparam int USED_W = 4;
  localparam int MASK_W = 16;

  localparam logic [CMD_W-1:0] CMD_SET_EXEC     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_MEM      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK_FETCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK_ACCESS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESUME       = 3'd5;

  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE  = 2'd2;

  // One item in flight through the chain, with its partial result.
  typedef struct packed {
    logic              vld;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic [STS_W-1:0]  status;
    logic              found;
    logic [USED_W-1:0] used;
    logic              hit;
    logic [MASK_W-1:0] mask;
  } token_t;

endpackage
`default_nettype wire

// ===== rtl/bct_cell.sv =====
// One breakpoint entry plus its comparator; passes the item token onward.
// Depends on bct_pkg.
`default_nettype none
module bct_cell #(
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire bct_pkg::token_t tok_i,
  output bct_pkg::token_t      tok_o
);

  localparam int MIDX = (IDX < bct_pkg::MASK_W) ? IDX : 0;

  logic                        valid_r;
  logic                        is_mem_r;
  logic [bct_pkg::ADDR_W-1:0]  addr_r;
  bct_pkg::token_t             tok_r;
  bct_pkg::token_t             tok_nxt;
  logic                        is_set;
  logic                        is_check;
  logic                        take_set;
  logic                        match;

  always_comb begin
    is_set   = (tok_i.cmd == bct_pkg::CMD_SET_EXEC) || (tok_i.cmd == bct_pkg::CMD_SET_MEM);
    is_check = (tok_i.cmd == bct_pkg::CMD_CHECK_FETCH) ||
               (tok_i.cmd == bct_pkg::CMD_CHECK_ACCESS);
    take_set = is_set && !tok_i.found && !valid_r;
    match    = is_check && valid_r && (addr_r == tok_i.addr) &&
               (is_mem_r == (tok_i.cmd == bct_pkg::CMD_CHECK_ACCESS));
    tok_nxt  = tok_i;
    if (take_set) begin
      tok_nxt.found = 1'b1;
      tok_nxt.used  = bct_pkg::USED_W'(IDX);
    end
    if (match) begin
      if (!tok_i.hit) begin
        tok_nxt.used = bct_pkg::USED_W'(IDX);
      end
      tok_nxt.hit = 1'b1;
      if (IDX < bct_pkg::MASK_W) begin
        tok_nxt.mask[MIDX] = 1'b1;
      end
    end
  end

  // Entry storage: only valid needs reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv && tok_i.vld) begin
      if (take_set) begin
        valid_r <= 1'b1;
      end else if ((tok_i.cmd == bct_pkg::CMD_CLEAR) &&
                   (tok_i.slot == bct_pkg::SLOT_W'(IDX))) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_i.vld && take_set) begin
      is_mem_r <= (tok_i.cmd == bct_pkg::CMD_SET_MEM);
      addr_r   <= tok_i.addr;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ===== rtl/breakpoint_comparator_table_core.sv =====
// Each cell in the chain registers the token, and an output register holds the
// result. Throughput: one item per cycle; the whole chain advances together and
// stalls only while out_tvalid is high and out_tready is low.
// Reset (rst_n low, synchronous): all entries invalid, halt flag set, chain empty.
// Top level of the breakpoint comparator table; depends on bct_pkg, bct_cell
// and breakpoint_comparator_table_core_defines.svh.
`default_nettype none
`include "breakpoint_comparator_table_core_defines.svh"
module breakpoint_comparator_table_core #(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] command, [34:3] address, [42:35] slot_number, [47:43] zero
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [5:2] slot_used, [6] hit, [22:7] hit_mask, [23] halted
  output logic [23:0]      out_tdata
);

  // Token chain: tok[0] is the incoming item, tok[ENTRIES] leaves the last cell.
  bct_pkg::token_t tok [ENTRIES+1];
  bct_pkg::token_t tok_in;

  logic                        adv;
  logic                        out_vld_r;
  logic [bct_pkg::STS_W-1:0]   sts_r;
  logic [bct_pkg::USED_W-1:0]  used_r;
  logic                        hit_r;
  logic [bct_pkg::MASK_W-1:0]  mask_r;
  logic                        halt_r;
  logic                        halt_nxt;
  logic [bct_pkg::STS_W-1:0]   sts_nxt;
  logic [bct_pkg::USED_W-1:0]  used_nxt;
  bct_pkg::token_t             last;
  logic                        last_set;

  // Advance the whole chain whenever the output slot is free or being taken.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // Build the entry token; flag an out-of-range clear up front.
  always_comb begin
    tok_in        = '0;
    tok_in.vld    = in_tvalid;
    tok_in.cmd    = in_tdata[2:0];
    tok_in.addr   = in_tdata[34:3];
    tok_in.slot   = in_tdata[42:35];
    tok_in.status = bct_pkg::STS_OK;
    if ((in_tdata[2:0] == bct_pkg::CMD_CLEAR) &&
        (32'(in_tdata[42:35]) >= 32'(ENTRIES))) begin
      tok_in.status = bct_pkg::STS_RANGE;
    end
  end

  assign tok[0] = tok_in;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bct_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // Finish the item: table-full status and the halt flag update.
  always_comb begin
    last     = tok[ENTRIES];
    last_set = (last.cmd == bct_pkg::CMD_SET_EXEC) || (last.cmd == bct_pkg::CMD_SET_MEM);
    sts_nxt  = last.status;
    used_nxt = last.used;
    halt_nxt = halt_r;
    if (last_set) begin
      halt_nxt = 1'b1;
      if (!last.found) begin
        sts_nxt  = bct_pkg::STS_FULL;
        used_nxt = '0;
      end
    end else if (last.hit) begin
      halt_nxt = 1'b1;
    end else if (last.cmd == bct_pkg::CMD_RESUME) begin
      halt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      halt_r    <= 1'b1;
    end else if (adv) begin
      out_vld_r <= last.vld;
      if (last.vld) begin
        halt_r <= halt_nxt;
      end
    end
  end

  // Result payload; hold while stalled.
  always_ff @(posedge clk) begin
    if (adv && last.vld) begin
      sts_r  <= sts_nxt;
      used_r <= used_nxt;
      hit_r  <= last.hit;
      mask_r <= last.mask;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {halt_r, mask_r, hit_r, used_r, sts_r};

  // A hit always leaves the block halted.
  `BCT_ASSERT_NOW(a_hit_halts, out_vld_r && hit_r, halt_r)
  // Any mask bit implies the hit flag.
  `BCT_ASSERT_NOW(a_mask_hit, out_vld_r && (mask_r != '0), hit_r)
  // An error status never comes with a hit.
  `BCT_ASSERT_NOW(a_err_nohit, out_vld_r && (sts_r != bct_pkg::STS_OK), !hit_r)
  // The halt flag only moves when the chain advances.
  `BCT_ASSERT_NEXT(a_halt_hold, !adv, $stable(halt_r))

endmodule
`default_nettype wire

// ===== tb/sv/bp_table_checker.sv =====
// Checker for the breakpoint comparator table: watches both streams, keeps its own
// copy of the breakpoint entries and halt flag, and compares each result item.
// Depends on bct_pkg for command and status codes and field widths.
`timescale 1ns / 1ps
module bp_table_checker
  import bct_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Same bit order as out_tdata, highest field first.
  typedef struct packed {
    logic              halted;
    logic [MASK_W-1:0] hit_mask;
    logic              hit;
    logic [USED_W-1:0] slot_used;
    logic [STS_W-1:0]  status;
  } bp_result_t;

  logic              bp_valid  [ENTRIES];
  logic              bp_is_mem [ENTRIES];
  logic [ADDR_W-1:0] bp_addr   [ENTRIES];
  logic              halt_flag;

  bp_result_t expected_results[$];
  bp_result_t want;
  bp_result_t got;

  initial fail_count = 0;
  initial pending = 0;

  // Apply one command to the entry table and return the result it produces.
  function automatic bp_result_t apply_bp_command(logic [CMD_W-1:0] cmd,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [SLOT_W-1:0] slot);
    bp_result_t r;
    bit found;
    bit want_mem;
    r = '0;
    found = 1'b0;
    want_mem = (cmd == CMD_CHECK_ACCESS);
    case (cmd)
      CMD_SET_EXEC, CMD_SET_MEM: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && !bp_valid[i]) begin
            bp_valid[i]  = 1'b1;
            bp_is_mem[i] = (cmd == CMD_SET_MEM);
            bp_addr[i]   = addr;
            r.slot_used  = USED_W'(i);
            found        = 1'b1;
          end
        end
        if (!found) r.status = STS_FULL;
        halt_flag = 1'b1;
      end
      CMD_CLEAR: begin
        if (slot >= ENTRIES) r.status = STS_RANGE;
        else bp_valid[IDX_W'(slot)] = 1'b0;
      end
      CMD_CHECK_FETCH, CMD_CHECK_ACCESS: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (bp_valid[i] && bp_is_mem[i] == want_mem && bp_addr[i] == addr) begin
            if (!r.hit) r.slot_used = USED_W'(i);
            r.hit = 1'b1;
            if (i < MASK_W) r.hit_mask[i] = 1'b1;
          end
        end
        if (r.hit) halt_flag = 1'b1;
      end
      CMD_RESUME: halt_flag = 1'b0;
      default: ;
    endcase
    r.halted = halt_flag;
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        bp_valid[i]  = 1'b0;
        bp_is_mem[i] = 1'b0;
        bp_addr[i]   = '0;
      end
      halt_flag = 1'b1;
      expected_results.delete();
      pending <= 0;
    end else begin
      // Retire first: the block's latency keeps an item from coming out the
      // cycle it goes in.
      if (out_tvalid && out_tready) begin
        got = bp_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("slot_used", want.slot_used, got.slot_used);
          compare_field("hit", want.hit, got.hit);
          compare_field("hit_mask", want.hit_mask, got.hit_mask);
          compare_field("halted", want.halted, got.halted);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_bp_command(in_tdata[2:0], in_tdata[34:3],
                                                    in_tdata[42:35]));
      pending <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the breakpoint comparator table testbench: clock, reset, stimulus and
// verdict. Depends on bct_pkg, the block and bp_table_checker.
`timescale 1ns / 1ps
module tb;
  import bct_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int RAND_ITEMS  = 1170;
  localparam int CALM_ITEMS  = 150;   // tail of the run with no idling on either side
  localparam int PHASE_LEN   = 40;
  localparam int POOL_DEPTH  = 24;

  // Command codes the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  // Random phase flavors: bias toward filling, draining or probing the table.
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_PROBE = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  int          fail_count;
  int          pending;

  // Percent chance of a gap before an item / of a stall burst on the result side.
  int in_gap_pct = 20;
  int out_stall_pct = 20;

  // Recently set breakpoint addresses, so that checks actually hit.
  logic [ADDR_W-1:0] addr_pool[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  breakpoint_comparator_table_core #(
    .ENTRIES(NUM_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bp_table_checker #(
    .ENTRIES(NUM_ENTRIES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Pack command, address and slot number in tdata order, pad bits zero.
  function automatic logic [47:0] pack_item(logic [CMD_W-1:0] cmd,
                                            logic [ADDR_W-1:0] addr,
                                            logic [SLOT_W-1:0] slot);
    return {5'b0, slot, addr, cmd};
  endfunction

  function automatic void remember_addr(logic [ADDR_W-1:0] addr);
    addr_pool.push_back(addr);
    if (addr_pool.size() > POOL_DEPTH) void'(addr_pool.pop_front());
  endfunction

  // Mostly recently set addresses, plus the extremes and plain noise.
  function automatic logic [ADDR_W-1:0] pick_probe_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65 && addr_pool.size() > 0)
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    if (roll < 75) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom();
  endfunction

  // Present one item at the falling edge and hold it until the block takes it.
  // Enter and leave on a falling edge, so tvalid changes once per step at most.
  task automatic send_item(logic [47:0] item);
    if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result-side back pressure: random stall bursts, otherwise ready.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct)
          stall_left = $urandom_range(1, 5);
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int                n;
    int                phase_kind;
    int                roll;
    int                set_w;
    int                clear_w;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Probe the empty table first: the halt flag comes out of
    // reset set.
    send_item(pack_item(CMD_CHECK_FETCH, '0, '0));
    send_item(pack_item(CMD_RESUME, '0, '1));
    send_item(pack_item(CMD_SET_EXEC, '0, '0));
    send_item(pack_item(CMD_RESUME, '1, '0));
    // Same address twice: both slots must hit.
    send_item(pack_item(CMD_SET_EXEC, '0, '1));
    send_item(pack_item(CMD_SET_MEM, '1, '0));
    send_item(pack_item(CMD_RESUME, '0, '0));
    send_item(pack_item(CMD_CHECK_FETCH, '0, '0));
    send_item(pack_item(CMD_CHECK_ACCESS, '1, '0));
    // Right address, wrong kind: no hit, halt unchanged.
    send_item(pack_item(CMD_RESUME, '0, '0));
    send_item(pack_item(CMD_CHECK_FETCH, '1, '0));
    send_item(pack_item(CMD_CHECK_ACCESS, '0, '0));
    // Slot numbers just past the table and at the top of the field.
    send_item(pack_item(CMD_CLEAR, '0, 8'(NUM_ENTRIES)));
    send_item(pack_item(CMD_CLEAR, '1, 8'd255));
    // Clearing a free slot is harmless; clearing slot 0 frees the lowest one.
    send_item(pack_item(CMD_CLEAR, '0, 8'(NUM_ENTRIES - 1)));
    send_item(pack_item(CMD_CLEAR, '0, '0));
    send_item(pack_item(CMD_CHECK_FETCH, '0, '0));
    send_item(pack_item(CMD_UNUSED_LO, '1, '1));
    send_item(pack_item(CMD_UNUSED_HI, '0, '0));
    // Fill every free slot, then one more set finds the table full.
    for (n = 0; n < NUM_ENTRIES - 1; n++) begin
      addr = $urandom();
      remember_addr(addr);
      send_item(pack_item($urandom_range(0, 1) ? CMD_SET_MEM : CMD_SET_EXEC, addr, '0));
    end

    // Random part in phases of changing flavor and idling.
    phase_kind = PH_PROBE;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        phase_kind    = $urandom_range(PH_FILL, PH_PROBE);
        in_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      end
      if (n >= RAND_ITEMS - CALM_ITEMS) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end

      case (phase_kind)
        PH_FILL:  begin set_w = 50; clear_w = 10; end
        PH_DRAIN: begin set_w = 10; clear_w = 45; end
        default:  begin set_w = 15; clear_w = 15; end
      endcase

      roll = $urandom_range(0, 99);
      addr = $urandom();
      slot = 8'($urandom_range(0, 255));
      if (roll < set_w) begin
        cmd = $urandom_range(0, 1) ? CMD_SET_MEM : CMD_SET_EXEC;
        // Now and then reuse an address to stack duplicate entries.
        if (addr_pool.size() > 0 && $urandom_range(0, 3) == 0) addr = pick_probe_addr();
        remember_addr(addr);
      end else if (roll < set_w + clear_w) begin
        cmd  = CMD_CLEAR;
        slot = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(NUM_ENTRIES, 255))
                                           : 8'($urandom_range(0, NUM_ENTRIES - 1));
      end else if (roll < 90) begin
        cmd  = $urandom_range(0, 1) ? CMD_CHECK_ACCESS : CMD_CHECK_FETCH;
        addr = pick_probe_addr();
      end else if (roll < 97) begin
        cmd = CMD_RESUME;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      end
      send_item(pack_item(cmd, addr, slot));
    end

    // Drop valid, drain the pipeline, then allow a full chain's worth of quiet.
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (NUM_ENTRIES + 4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
